@@ rtl/core/boundary_fill_engine_macros.svh @@
// Assertion shorthands used by the checker file.
// They expect signals named clk and rst in the scope where they are used.
`ifndef BOUNDARY_FILL_ENGINE_MACROS_SVH
`define BOUNDARY_FILL_ENGINE_MACROS_SVH

// Checked only outside reset
`define BFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every clock edge, including during reset
`define BFE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/core/bfe_pkg.sv @@
package bfe_pkg;

  // Field widths on the stream ports
  localparam int KIND_W     = 2;
  localparam int COORD_W    = 7;
  localparam int CFIELD_W   = 4;
  localparam int COUNT_W    = 15;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Default raster geometry
  localparam int DEF_RASTER_WIDTH  = 128;
  localparam int DEF_RASTER_HEIGHT = 128;
  localparam int DEF_COLOR_BITS    = 4;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FILL  = 2'd2;

  // Neighbor directions, in visiting order
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_YP = 2'd1;
  localparam logic [1:0] DIR_XM = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [CFIELD_W-1:0] color;
    logic [CFIELD_W-1:0] boundary_color;
  } req_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  filled_count;
    logic [CFIELD_W-1:0] pixel_color;
  } res_t;

endpackage

@@ rtl/core/bfe_ram.sv @@
// Simple dual-port RAM: one write port, one read port with registered data
module bfe_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16384,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/bfe_step.sv @@
// Neighbor unit: steps one pixel in a direction and flags raster edges
module bfe_step import bfe_pkg::*; #(
  parameter int RASTER_WIDTH  = DEF_RASTER_WIDTH,
  parameter int RASTER_HEIGHT = DEF_RASTER_HEIGHT,
  localparam int XW = $clog2(RASTER_WIDTH),
  localparam int YW = $clog2(RASTER_HEIGHT)
) (
  input  logic [XW-1:0] px,
  input  logic [YW-1:0] py,
  input  logic [1:0]    dir,
  input  logic          self_sel,
  output logic [XW-1:0] nx,
  output logic [YW-1:0] ny,
  output logic          on_raster
);

  localparam logic [XW-1:0] X_LAST = XW'(RASTER_WIDTH - 1);
  localparam logic [YW-1:0] Y_LAST = YW'(RASTER_HEIGHT - 1);

  // self_sel passes the pixel itself (seed check)
  always_comb begin
    nx        = px;
    ny        = py;
    on_raster = 1'b1;
    if (!self_sel) begin
      unique case (dir)
        DIR_XP: begin
          nx        = px + XW'(1);
          on_raster = (px != X_LAST);
        end
        DIR_YP: begin
          ny        = py + YW'(1);
          on_raster = (py != Y_LAST);
        end
        DIR_XM: begin
          nx        = px - XW'(1);
          on_raster = (px != '0);
        end
        DIR_YM: begin
          ny        = py - YW'(1);
          on_raster = (py != '0);
        end
      endcase
    end
  end

endmodule

@@ rtl/core/bfe_ctrl.sv @@
// Sequencer: clearing pass, pixel access and the stack-driven fill walk
module bfe_ctrl import bfe_pkg::*; #(
  parameter int RASTER_WIDTH  = DEF_RASTER_WIDTH,
  parameter int RASTER_HEIGHT = DEF_RASTER_HEIGHT,
  parameter int COLOR_BITS    = DEF_COLOR_BITS,
  localparam int XW = $clog2(RASTER_WIDTH),
  localparam int YW = $clog2(RASTER_HEIGHT),
  localparam int AW = XW + YW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res,
  output logic                  frame_we,
  output logic [AW-1:0]         frame_waddr,
  output logic [COLOR_BITS-1:0] frame_wdata,
  output logic [AW-1:0]         frame_raddr,
  input  logic [COLOR_BITS-1:0] frame_rdata,
  output logic                  stack_we,
  output logic [AW-1:0]         stack_waddr,
  output logic [AW-1:0]         stack_wdata,
  output logic [AW-1:0]         stack_raddr,
  input  logic [AW-1:0]         stack_rdata
);

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_READ_WAIT = 3'd2;
  localparam logic [2:0] S_NB_READ   = 3'd3;
  localparam logic [2:0] S_NB_CHK    = 3'd4;
  localparam logic [2:0] S_POP       = 3'd5;
  localparam logic [2:0] S_POP_WAIT  = 3'd6;
  localparam logic [2:0] S_DONE      = 3'd7;

  localparam logic [AW:0]        TOP_ONE   = (AW + 1)'(1);
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  logic [2:0]            state, state_next;
  logic [AW-1:0]         clr_addr, clr_addr_next;
  logic [AW:0]           top, top_next, top_dec;
  logic [XW-1:0]         cur_x, cur_x_next, nb_x, nb_x_next, nx, in_x;
  logic [YW-1:0]         cur_y, cur_y_next, nb_y, nb_y_next, ny, in_y;
  logic [1:0]            dir, dir_next, adv_dir;
  logic                  seed_phase, seed_phase_next;
  logic [COUNT_W-1:0]    count, count_next;
  logic [COLOR_BITS-1:0] fill_c, fill_c_next, bound_c, bound_c_next;
  logic [COLOR_BITS-1:0] in_color, in_bound;
  logic [CFIELD_W-1:0]   res_pix, res_pix_next;
  logic [2:0]            adv_state;
  logic                  n_in, in_inside, last_dir;

  // Shared neighbor unit
  bfe_step #(
    .RASTER_WIDTH  (RASTER_WIDTH),
    .RASTER_HEIGHT (RASTER_HEIGHT)
  ) u_step (
    .px        (cur_x),
    .py        (cur_y),
    .dir       (dir),
    .self_sel  (seed_phase),
    .nx        (nx),
    .ny        (ny),
    .on_raster (n_in)
  );

  // Request decode
  assign in_inside = (32'(req.x) < 32'(RASTER_WIDTH)) && (32'(req.y) < 32'(RASTER_HEIGHT));
  assign in_x      = XW'(req.x);
  assign in_y      = YW'(req.y);
  assign in_color  = COLOR_BITS'(req.color);
  assign in_bound  = COLOR_BITS'(req.boundary_color);

  // Direction advance; the seed check and the last direction return to the stack
  assign top_dec   = top - TOP_ONE;
  assign last_dir  = seed_phase || (dir == DIR_YM);
  assign adv_state = last_dir ? S_POP : S_NB_READ;
  assign adv_dir   = last_dir ? DIR_XP : dir + 2'd1;

  assign res.pixel_color  = res_pix;
  assign res.filled_count = count;

  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    top_next        = top;
    cur_x_next      = cur_x;
    cur_y_next      = cur_y;
    nb_x_next       = nb_x;
    nb_y_next       = nb_y;
    dir_next        = dir;
    seed_phase_next = seed_phase;
    count_next      = count;
    fill_c_next     = fill_c;
    bound_c_next    = bound_c;
    res_pix_next    = res_pix;
    req_ready       = 1'b0;
    res_valid       = 1'b0;
    frame_we        = 1'b0;
    frame_waddr     = {nb_y, nb_x};
    frame_wdata     = fill_c;
    frame_raddr     = {ny, nx};
    stack_we        = 1'b0;
    stack_waddr     = top[AW-1:0];
    stack_wdata     = {nb_y, nb_x};
    stack_raddr     = top_dec[AW-1:0];

    unique case (state)
      S_CLEAR: begin
        frame_we      = 1'b1;
        frame_waddr   = clr_addr;
        frame_wdata   = '0;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == '1) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        req_ready   = 1'b1;
        frame_raddr = {in_y, in_x};
        if (req_valid) begin
          res_pix_next = '0;
          count_next   = '0;
          state_next   = S_DONE;
          case (req.kind)
            KIND_WRITE: begin
              if (in_inside) begin
                frame_we    = 1'b1;
                frame_waddr = {in_y, in_x};
                frame_wdata = in_color;
              end
            end
            KIND_READ: begin
              if (in_inside) begin
                state_next = S_READ_WAIT;
              end
            end
            KIND_FILL: begin
              fill_c_next     = in_color;
              bound_c_next    = in_bound;
              cur_x_next      = in_x;
              cur_y_next      = in_y;
              seed_phase_next = 1'b1;
              dir_next        = DIR_XP;
              top_next        = '0;
              if (in_inside) begin
                state_next = S_NB_READ;
              end
            end
            default: ;
          endcase
        end
      end

      S_READ_WAIT: begin
        res_pix_next = CFIELD_W'(frame_rdata);
        state_next   = S_DONE;
      end

      // Look up the next neighbor, skipping those off the raster
      S_NB_READ: begin
        nb_x_next = nx;
        nb_y_next = ny;
        if (n_in) begin
          state_next = S_NB_CHK;
        end else begin
          state_next      = adv_state;
          dir_next        = adv_dir;
          seed_phase_next = 1'b0;
        end
      end

      // Paint and push when neither boundary nor fill color
      S_NB_CHK: begin
        if ((frame_rdata != bound_c) && (frame_rdata != fill_c)) begin
          frame_we = 1'b1;
          stack_we = 1'b1;
          top_next = top + TOP_ONE;
          if (count != '1) begin
            count_next = count + COUNT_ONE;
          end
        end
        state_next      = adv_state;
        dir_next        = adv_dir;
        seed_phase_next = 1'b0;
      end

      S_POP: begin
        if (top == '0) begin
          state_next = S_DONE;
        end else begin
          top_next   = top_dec;
          state_next = S_POP_WAIT;
        end
      end

      S_POP_WAIT: begin
        {cur_y_next, cur_x_next} = stack_rdata;
        dir_next                 = DIR_XP;
        state_next               = S_NB_READ;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      top        <= '0;
      seed_phase <= 1'b0;
      dir        <= DIR_XP;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      top        <= top_next;
      seed_phase <= seed_phase_next;
      dir        <= dir_next;
    end
  end

  // Working data
  always_ff @(posedge clk) begin
    cur_x   <= cur_x_next;
    cur_y   <= cur_y_next;
    nb_x    <= nb_x_next;
    nb_y    <= nb_y_next;
    count   <= count_next;
    fill_c  <= fill_c_next;
    bound_c <= bound_c_next;
    res_pix <= res_pix_next;
  end

endmodule

@@ rtl/core/boundary_fill_engine.sv @@
// Four-connected boundary fill engine over a RASTER_WIDTH x RASTER_HEIGHT frame of
// COLOR_BITS-bit pixels. Each request yields one result. After reset the frame is
// cleared by a pass over all 2**(clog2(RASTER_WIDTH)+clog2(RASTER_HEIGHT)) addresses
// (16384 by default) with s_axis_tready low. A fill checks the seed, then for each
// stack pop looks up the four neighbors in turn, skipping those off the raster;
// its speed is set by the single frame RAM read port, which serves one neighbor
// lookup at a time. Out-of-range coordinates are ignored and read as 0; filled_count
// saturates at 32767.
module boundary_fill_engine import bfe_pkg::*; #(
  parameter int RASTER_WIDTH  = DEF_RASTER_WIDTH,
  parameter int RASTER_HEIGHT = DEF_RASTER_HEIGHT,
  parameter int COLOR_BITS    = DEF_COLOR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x [6:0], y [13:7], color [17:14], boundary_color [21:18], zero [23:22]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [1:0]
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // pixel_color [3:0], filled_count [18:4], zero [23:19]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int XW = $clog2(RASTER_WIDTH);
  localparam int YW = $clog2(RASTER_HEIGHT);
  localparam int AW = XW + YW;
  localparam int PIXEL_SLOTS = 1 << AW;

  req_t                  req;
  res_t                  res;
  logic                  res_valid, res_ready;
  logic                  frame_we, stack_we;
  logic [AW-1:0]         frame_waddr, frame_raddr;
  logic [COLOR_BITS-1:0] frame_wdata, frame_rdata;
  logic [AW-1:0]         stack_waddr, stack_wdata, stack_raddr, stack_rdata;

  // Request unpacking
  assign req.kind           = s_axis_tuser;
  assign req.x              = s_axis_tdata[6:0];
  assign req.y              = s_axis_tdata[13:7];
  assign req.color          = s_axis_tdata[17:14];
  assign req.boundary_color = s_axis_tdata[21:18];

  bfe_ctrl #(
    .RASTER_WIDTH  (RASTER_WIDTH),
    .RASTER_HEIGHT (RASTER_HEIGHT),
    .COLOR_BITS    (COLOR_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (s_axis_tvalid),
    .req_ready   (s_axis_tready),
    .req         (req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .frame_we    (frame_we),
    .frame_waddr (frame_waddr),
    .frame_wdata (frame_wdata),
    .frame_raddr (frame_raddr),
    .frame_rdata (frame_rdata),
    .stack_we    (stack_we),
    .stack_waddr (stack_waddr),
    .stack_wdata (stack_wdata),
    .stack_raddr (stack_raddr),
    .stack_rdata (stack_rdata)
  );

  // Frame buffer
  bfe_ram #(
    .WIDTH (COLOR_BITS),
    .DEPTH (PIXEL_SLOTS)
  ) u_frame (
    .clk   (clk),
    .we    (frame_we),
    .waddr (frame_waddr),
    .wdata (frame_wdata),
    .raddr (frame_raddr),
    .rdata (frame_rdata)
  );

  // Pending pixel stack, {y, x} per entry
  bfe_ram #(
    .WIDTH (AW),
    .DEPTH (PIXEL_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // Output register
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {(OUT_DATA_W - COUNT_W - CFIELD_W)'(0), res.filled_count,
                       res.pixel_color};
    end
  end

endmodule

@@ rtl/core/bfe_checker.sv @@
`include "boundary_fill_engine_macros.svh"

// Port-level checks on the fill engine
module bfe_checker import bfe_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Clearing pass keeps the input closed right after reset
  `BFE_ASSERT_ALWAYS(a_closed_after_reset, rst |=> !s_axis_tready, "ready during clear")

  // One request at a time: input closes after each accepted request
  `BFE_ASSERT(a_one_at_a_time, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready after accept")

  // Stalled result holds
  `BFE_ASSERT(a_result_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")

  // A result never carries both a pixel and a count
  `BFE_ASSERT(a_one_field, m_axis_tvalid |-> (m_axis_tdata[3:0] == 4'd0 || m_axis_tdata[18:4] == 15'd0), "pixel and count")

  // Padding stays zero
  `BFE_ASSERT(a_pad_zero, m_axis_tvalid |-> m_axis_tdata[23:19] == 5'd0, "pad bits set")

endmodule

bind boundary_fill_engine bfe_checker u_bfe_checker (.*);

@@ test/boundary_fill_engine_tb.sv @@
`timescale 1ns / 100ps

module boundary_fill_engine_tb;
  import bfe_pkg::*;

  localparam int RW              = DEF_RASTER_WIDTH;
  localparam int RH              = DEF_RASTER_HEIGHT;
  localparam int PIXELS          = RW * RH;
  localparam int COUNT_SAT       = 32767;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1800;
  // random fills that would paint more than this are turned into no-op fills
  localparam int FILL_CAP        = 512;
  // must outlast a full-raster fill, during which nothing is accepted
  localparam int STALL_LIMIT     = 600000;
  localparam int TAIL_CYCLES     = 64;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // x [6:0], y [13:7], color [17:14], boundary_color [21:18], zero [23:22]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // kind [1:0]
  logic [KIND_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // pixel_color [3:0], filled_count [18:4], zero [23:19]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int sent_count = 0;
  int stall_cycles = 0;

  // Shadow framebuffer plus queue of expected results
  class fill_scoreboard;
    logic [CFIELD_W-1:0] frame [PIXELS];
    logic [CFIELD_W-1:0] frame_saved [PIXELS];
    int   stack_addr [PIXELS];
    int   top;
    res_t expected_results [$];
    int   errors;

    function new();
      foreach (frame[i]) frame[i] = '0;
      top = 0;
      errors = 0;
    endfunction

    // paint and push one pixel unless it is off-raster, boundary or already filled
    function int paint(int cx, int cy, logic [CFIELD_W-1:0] fill,
                       logic [CFIELD_W-1:0] bound);
      int addr;
      if (cx < 0 || cy < 0 || cx >= RW || cy >= RH) return 0;
      addr = cy * RW + cx;
      if (frame[addr] == bound || frame[addr] == fill) return 0;
      frame[addr] = fill;
      stack_addr[top] = addr;
      top++;
      return 1;
    endfunction

    // stack-based fill, neighbors in order +x, +y, -x, -y
    function int flood_region(int sx, int sy, logic [CFIELD_W-1:0] fill,
                              logic [CFIELD_W-1:0] bound);
      int painted;
      int addr;
      int px;
      int py;
      top = 0;
      painted = paint(sx, sy, fill, bound);
      while (top > 0) begin
        top--;
        addr = stack_addr[top];
        px = addr % RW;
        py = addr / RW;
        painted += paint(px + 1, py, fill, bound);
        painted += paint(px, py + 1, fill, bound);
        painted += paint(px - 1, py, fill, bound);
        painted += paint(px, py - 1, fill, bound);
      end
      return (painted > COUNT_SAT) ? COUNT_SAT : painted;
    endfunction

    // size of a fill without changing the frame
    function int region_size(int sx, int sy, logic [CFIELD_W-1:0] fill,
                             logic [CFIELD_W-1:0] bound);
      int n;
      frame_saved = frame;
      n = flood_region(sx, sy, fill, bound);
      frame = frame_saved;
      return n;
    endfunction

    function logic [CFIELD_W-1:0] pixel_at(int x, int y);
      return frame[y * RW + x];
    endfunction

    function void note_request(req_t r);
      res_t e;
      int   addr;
      e = '0;
      addr = int'(r.y) * RW + int'(r.x);
      case (r.kind)
        KIND_WRITE: frame[addr] = r.color;
        KIND_READ:  e.pixel_color = frame[addr];
        KIND_FILL:  e.filled_count = COUNT_W'(flood_region(r.x, r.y, r.color,
                                                           r.boundary_color));
        default: ;
      endcase
      expected_results.push_back(e);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] d);
      res_t                e;
      logic [CFIELD_W-1:0] pix;
      logic [COUNT_W-1:0]  cnt;
      pix = d[CFIELD_W-1:0];
      cnt = d[CFIELD_W +: COUNT_W];
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: tdata=%h", d);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (pix !== e.pixel_color) begin
        $error("pixel_color: expected %0d, actual %0d", e.pixel_color, pix);
        errors++;
      end
      if (cnt !== e.filled_count) begin
        $error("filled_count: expected %0d, actual %0d", e.filled_count, cnt);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  fill_scoreboard sb = new();

  boundary_fill_engine uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t make_request(logic [KIND_W-1:0] k, int x, int y, int c, int b);
    req_t r;
    r.kind           = k;
    r.x              = COORD_W'(x);
    r.y              = COORD_W'(y);
    r.color          = CFIELD_W'(c);
    r.boundary_color = CFIELD_W'(b);
    return r;
  endfunction

  // Present one request after a random gap (none when tx_steady) and hold it until accepted
  task automatic send_request(req_t r);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.boundary_color, r.color, r.y, r.x};
    s_axis_tuser  <= r.kind;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(r);
    if (r.kind != KIND_UNUSED) sent_count++;
  endtask

  task automatic do_write(int x, int y, int c);
    send_request(make_request(KIND_WRITE, x, y, c, $urandom_range(0, 15)));
  endtask

  task automatic do_read(int x, int y);
    send_request(make_request(KIND_READ, x, y, $urandom_range(0, 15),
                              $urandom_range(0, 15)));
  endtask

  // Guarded fills fall back to a seed-is-fill-colour fill when the region is big
  task automatic send_fill(int x, int y, int c, int b, bit guarded);
    if (guarded && sb.region_size(x, y, c, b) > FILL_CAP) c = sb.pixel_at(x, y);
    send_request(make_request(KIND_FILL, x, y, c, b));
  endtask

  // Hold off the sender until every result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Box outline in the boundary colour (sides on the raster edge left off),
  // stray pixels inside, a fill from inside, then reads back
  task automatic boxed_fill();
    int ix0;
    int ix1;
    int iy0;
    int iy1;
    int w;
    int h;
    int n;
    int gap_at;
    int bcol;
    int fcol;
    int ox [$];
    int oy [$];
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 8);
    case ($urandom_range(0, 5))
      0:       ix0 = 0;
      1:       ix0 = RW - w;
      default: ix0 = $urandom_range(0, RW - w);
    endcase
    case ($urandom_range(0, 5))
      0:       iy0 = 0;
      1:       iy0 = RH - h;
      default: iy0 = $urandom_range(0, RH - h);
    endcase
    ix1 = ix0 + w - 1;
    iy1 = iy0 + h - 1;
    bcol = $urandom_range(0, 15);
    n = $urandom_range(0, 3);
    repeat (n) do_write($urandom_range(ix0, ix1), $urandom_range(iy0, iy1),
                        $urandom_range(0, 15));
    for (int x = ix0 - 1; x <= ix1 + 1; x++) begin
      if (x >= 0 && x < RW) begin
        if (iy0 > 0) begin
          ox.push_back(x);
          oy.push_back(iy0 - 1);
        end
        if (iy1 < RH - 1) begin
          ox.push_back(x);
          oy.push_back(iy1 + 1);
        end
      end
    end
    for (int y = iy0; y <= iy1; y++) begin
      if (ix0 > 0) begin
        ox.push_back(ix0 - 1);
        oy.push_back(y);
      end
      if (ix1 < RW - 1) begin
        ox.push_back(ix1 + 1);
        oy.push_back(y);
      end
    end
    // now and then leave a hole so the fill leaks out
    gap_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, ox.size() - 1) : -1;
    foreach (ox[i]) begin
      if (i != gap_at) do_write(ox[i], oy[i], bcol);
    end
    fcol = ($urandom_range(0, 7) == 0) ? bcol : $urandom_range(0, 15);
    send_fill($urandom_range(ix0, ix1), $urandom_range(iy0, iy1), fcol, bcol, 1'b1);
    n = $urandom_range(1, 3);
    repeat (n) do_read($urandom_range(ix0, ix1), $urandom_range(iy0, iy1));
  endtask

  // Result side: random ready stalls unless rx_steady, check every accepted result
  initial begin
    int gap;
    forever begin
      gap = rx_steady ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && !rst));
      sb.check_result(m_axis_tdata);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** boundary_fill_engine: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int pick;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // cleared frame, unused kind, full-raster fills
    do_read(0, 0);
    send_request(make_request(KIND_UNUSED, RW - 1, 0, 15, 15));
    do_read(RW - 1, 0);
    send_fill(RW / 2, RH / 2, 5, 15, 1'b0);
    do_write(RW - 1, RH - 1, 15);
    do_read(RW - 1, RH - 1);
    send_fill(RW - 1, RH - 1, 3, 9, 1'b0);
    // seed is the boundary colour, then seed already the fill colour
    send_fill(10, 10, 7, 3, 1'b0);
    send_fill(10, 10, 3, 8, 1'b0);
    // corner pocket, fill colour equal to boundary colour
    do_write(2, 0, 8);
    do_write(2, 1, 8);
    do_write(0, 2, 8);
    do_write(1, 2, 8);
    do_write(1, 1, 6);
    send_fill(0, 0, 8, 8, 1'b0);
    do_read(1, 1);
    do_read(2, 2);
    // single-pixel pocket at the far corner
    do_write(RW - 2, RH - 1, 1);
    do_write(RW - 1, RH - 2, 1);
    send_fill(RW - 1, RH - 1, 2, 1, 1'b0);
    do_read(RW - 1, RH - 1);
    wait_drained();

    // random part
    sent_count = 0;
    while (sent_count < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 9) == 0) tx_steady = !tx_steady;
      if ($urandom_range(0, 9) == 0) rx_steady = !rx_steady;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        wait_drained();
      end else if (pick < 55) begin
        boxed_fill();
      end else if (pick < 70) begin
        do_write($urandom_range(0, RW - 1), $urandom_range(0, RH - 1), $urandom_range(0, 15));
      end else if (pick < 88) begin
        do_read($urandom_range(0, RW - 1), $urandom_range(0, RH - 1));
      end else if (pick < 93) begin
        send_request(make_request(KIND_UNUSED, $urandom_range(0, RW - 1),
                                  $urandom_range(0, RH - 1), $urandom_range(0, 15),
                                  $urandom_range(0, 15)));
      end else begin
        send_fill($urandom_range(0, RW - 1), $urandom_range(0, RH - 1),
                  $urandom_range(0, 15), $urandom_range(0, 15), 1'b1);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** boundary_fill_engine: PASSED **");
    end else begin
      $display("** boundary_fill_engine: FAILED **");
    end
    $finish;
  end

endmodule
